// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: hdl/srsa_pkg.sv
`timescale 1ns / 1ps
package srsa_pkg;
  localparam int MaxRows = 1024;
  localparam int RowW = $clog2(MaxRows);
  localparam logic [0:0] CmdAcc = 1'b0;
  localparam logic [0:0] CmdRead = 1'b1;
  localparam logic [0:0] RegRowCount = 1'b0;
  localparam logic [0:0] RegColCount = 1'b1;
  localparam logic [47:0] SumMax = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] SumMin = 48'h8000_0000_0000;
  localparam logic [19:0] CountMax = 20'hFFFFF;

  typedef struct packed {
    logic          cmd;
    logic          ok;
    logic [RowW-1:0] row;
    logic [23:0]   weight;
  } job_t;
endpackage

// File: hdl/srsa_front.sv
`timescale 1ns / 1ps
module srsa_front
  import srsa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        cmd,
  input  logic [9:0]  row,
  input  logic [19:0] col,
  input  logic [23:0] weight,
  input  logic [10:0] row_count,
  input  logic [20:0] column_count,
  input  logic        flush,
  output logic        q_valid,
  input  logic        q_ready,
  output job_t        q_job
);
  // Two-entry queue between classification and execution.
  job_t        mem_r [2];
  logic        wp_r, rp_r, wp_nxt, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  job_t        job;
  logic        push, pop;

  always_comb begin
    job.cmd = cmd;
    job.row = row[RowW-1:0];
    job.weight = weight;
    job.ok = ({1'b0, row} < row_count) && ({21'd0, row} < 31'(MaxRows))
             && (cmd == CmdRead || {1'b0, col} < column_count);
  end

  assign in_ready = (cnt_r != 2'd2) && !flush;
  assign push = in_valid && in_ready;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_job = mem_r[rp_r];
  assign wp_nxt = wp_r ^ push;
  assign rp_nxt = rp_r ^ pop;
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= job;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_no_overfill, clk, rst_n, cnt_r == 2'd2, !push, "queue overfilled")
  `ASSERT_IMPL(a_no_underflow, clk, rst_n, cnt_r == 2'd0, !pop, "queue underflow")
  `ASSERT_NEXT(a_cnt_track, clk, rst_n, push && !pop && cnt_r == 2'd0, cnt_r == 2'd1,
               "queue count lost a push")
endmodule

// File: hdl/srsa_divider.sv
`timescale 1ns / 1ps
module srsa_divider
  import srsa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [95:0]  dividend,
  input  logic [20:0]  divisor,
  output logic         done,
  output logic [95:0]  quotient
);
  // Restoring division, one quotient bit per cycle.
  logic [95:0] q_r, q_nxt;
  logic [21:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [21:0] sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r[20:0], q_r[95]};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = 22'd0;
      cnt_nxt = 7'd0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, divisor}) begin
        rem_nxt = sh - {1'b0, divisor};
        q_nxt = {q_r[94:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[94:0], 1'b0};
      end
      cnt_nxt = cnt_r + 7'd1;
      if (cnt_r == 7'd95) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign done = done_r;
  assign quotient = q_r;

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end
endmodule

// File: hdl/srsa_back.sv
`timescale 1ns / 1ps
module srsa_back
  import srsa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         flush,
  input  logic [20:0]  column_count,
  input  logic         q_valid,
  output logic         q_ready,
  input  job_t         q_job,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [23:0]  std_dev,
  output logic [47:0]  row_sum,
  output logic [63:0]  row_sum_squares,
  output logic [19:0]  entry_count,
  output logic         row_in_range
);
  localparam logic [3:0] StIdle = 4'd0, StRead = 4'd1, StAcc = 4'd2, StMul = 4'd3,
    StMulAdd = 4'd4, StDiv1 = 4'd5, StWait1 = 4'd6, StDiff = 4'd7, StWait2 = 4'd8,
    StSqrt = 4'd9, StOut = 4'd10, StClear = 4'd11, StMul2 = 4'd12;

  logic [47:0] sum_mem [MaxRows];
  logic [63:0] sq_mem [MaxRows];
  logic [19:0] cnt_mem [MaxRows];

  logic [3:0]  st_r, st_nxt;
  job_t        job_r, job_nxt;
  logic [47:0] s1_r;
  logic [63:0] s2_r;
  logic [19:0] c_r;
  logic [RowW-1:0] clr_r;
  logic        clr_done;
  logic [95:0] acc_r, acc_nxt;
  logic [47:0] mag_r;
  logic [1:0]  mstep_r, mstep_nxt;
  logic        div_start;
  logic [95:0] div_a;
  logic [20:0] div_b;
  logic [20:0] div_dn, div_dm;
  logic        div_done;
  logic [95:0] div_q;
  logic [63:0] sr_r, sr_nxt, bit_r, bit_nxt, rem_r, rem_nxt;
  logic [5:0]  sq_cnt_r, sq_cnt_nxt;
  logic        ov_r, ov_nxt;
  logic        ovalid_r, ovalid_nxt;
  logic [23:0] std_r, std_nxt;
  logic [47:0] osum_r, osum_nxt;
  logic [63:0] osq_r, osq_nxt;
  logic [19:0] ocnt_r, ocnt_nxt;
  logic        orng_r, orng_nxt;
  logic        we;
  logic [47:0] w_ext, new_sum, mag_nxt;
  logic [48:0] sum_wide;
  logic [47:0] w_sq48;
  logic [63:0] w_sq, new_sq;
  logic [64:0] sq_wide;
  logic [23:0] w_mag;
  logic [23:0] part_a;
  logic [47:0] pp;
  logic [63:0] trial;

  srsa_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .done(div_done), .quotient(div_q)
  );

  assign w_ext = {{24{job_r.weight[23]}}, job_r.weight};
  assign w_mag = job_r.weight[23] ? (24'd0 - job_r.weight) : job_r.weight;
  assign w_sq48 = {24'd0, w_mag} * {24'd0, w_mag};
  assign w_sq = {16'd0, w_sq48};
  assign sum_wide = {s1_r[47], s1_r} + {w_ext[47], w_ext};
  assign new_sum = (sum_wide[48] != sum_wide[47]) ? (sum_wide[48] ? SumMin : SumMax)
                                                   : sum_wide[47:0];
  assign sq_wide = {1'b0, s2_r} + {1'b0, w_sq};
  assign new_sq = sq_wide[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sq_wide[63:0];
  assign clr_done = (clr_r == RowW'(MaxRows - 1));
  assign mag_nxt = s1_r[47] ? (48'd0 - s1_r) : s1_r;
  assign part_a = mstep_r[0] ? mag_r[47:24] : mag_r[23:0];
  assign pp = part_a * (mstep_r[1] ? mag_r[47:24] : mag_r[23:0]);
  assign trial = sr_r + bit_r;
  assign div_dn = (column_count == 21'd0) ? 21'd1 : column_count;
  assign div_dm = (column_count > 21'd1) ? (column_count - 21'd1) : 21'd1;
  assign div_b = (st_r == StMulAdd || st_r == StWait2) ? div_dm : div_dn;

  always_comb begin
    st_nxt = st_r;
    job_nxt = job_r;
    acc_nxt = acc_r;
    mstep_nxt = mstep_r;
    div_start = 1'b0;
    div_a = acc_r;
    sr_nxt = sr_r;
    bit_nxt = bit_r;
    rem_nxt = rem_r;
    sq_cnt_nxt = sq_cnt_r;
    ov_nxt = ov_r;
    ovalid_nxt = ovalid_r && !out_ready;
    std_nxt = std_r;
    osum_nxt = osum_r;
    osq_nxt = osq_r;
    ocnt_nxt = ocnt_r;
    orng_nxt = orng_r;
    we = 1'b0;
    q_ready = 1'b0;
    case (st_r)
      StIdle: begin
        q_ready = 1'b1;
        if (q_valid) begin
          job_nxt = q_job;
          st_nxt = StRead;
          if (q_job.cmd == CmdAcc && !q_job.ok) begin
            st_nxt = StIdle;
          end
        end
      end
      StRead: begin
        if (job_r.cmd == CmdAcc) begin
          st_nxt = StAcc;
        end else if (!job_r.ok) begin
          st_nxt = StOut;
        end else begin
          acc_nxt = 96'd0;
          mstep_nxt = 2'd0;
          st_nxt = StMul;
        end
      end
      StAcc: begin
        we = 1'b1;
        st_nxt = StIdle;
      end
      StMul: begin
        st_nxt = StMul2;
      end
      StMul2: begin
        // Four 24x24 partial products, one per cycle.
        case (mstep_r)
          2'd0: acc_nxt = acc_r + {48'd0, pp};
          2'd1: acc_nxt = acc_r + {24'd0, pp, 24'd0};
          2'd2: acc_nxt = acc_r + {24'd0, pp, 24'd0};
          default: acc_nxt = acc_r + {pp, 48'd0};
        endcase
        mstep_nxt = mstep_r + 2'd1;
        if (mstep_r == 2'd3) begin
          st_nxt = StDiv1;
        end
      end
      StDiv1: begin
        div_start = 1'b1;
        st_nxt = StWait1;
      end
      StWait1: begin
        if (div_done) begin
          st_nxt = StDiff;
        end
      end
      StDiff: begin
        if (column_count == 21'd0) begin
          acc_nxt = 96'd0;
        end else begin
          acc_nxt = div_q;
        end
        st_nxt = StMulAdd;
      end
      StMulAdd: begin
        if (acc_r[95:64] != 32'd0 || acc_r[63:0] > s2_r) begin
          ov_nxt = 1'b1;
          div_a = 96'd0;
        end else begin
          ov_nxt = 1'b0;
          div_a = {32'd0, s2_r - acc_r[63:0]};
        end
        div_start = 1'b1;
        st_nxt = StWait2;
      end
      StWait2: begin
        if (div_done) begin
          sr_nxt = 64'd0;
          bit_nxt = 64'h4000_0000_0000_0000;
          rem_nxt = div_q[63:0];
          sq_cnt_nxt = 6'd0;
          st_nxt = StSqrt;
        end
      end
      StSqrt: begin
        if (rem_r >= trial) begin
          rem_nxt = rem_r - trial;
          sr_nxt = (sr_r >> 1) + bit_r;
        end else begin
          sr_nxt = sr_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        sq_cnt_nxt = sq_cnt_r + 6'd1;
        if (sq_cnt_r == 6'd31) begin
          st_nxt = StOut;
        end
      end
      StOut: begin
        if (!ovalid_r || out_ready) begin
          if (!job_r.ok || ov_r) begin
            std_nxt = 24'd0;
          end else begin
            std_nxt = (sr_r[63:24] != 40'd0) ? 24'hFFFFFF : sr_r[23:0];
          end
          osum_nxt = job_r.ok ? s1_r : 48'd0;
          osq_nxt = job_r.ok ? s2_r : 64'd0;
          ocnt_nxt = job_r.ok ? c_r : 20'd0;
          orng_nxt = job_r.ok;
          ovalid_nxt = 1'b1;
          st_nxt = StIdle;
        end
      end
      StClear: begin
        if (clr_done) begin
          st_nxt = StIdle;
        end
      end
      default: st_nxt = StIdle;
    endcase
    if (flush) begin
      st_nxt = StClear;
    end
  end

  assign out_valid = ovalid_r;
  assign std_dev = std_r;
  assign row_sum = osum_r;
  assign row_sum_squares = osq_r;
  assign entry_count = ocnt_r;
  assign row_in_range = orng_r;

  always_ff @(posedge clk) begin
    if (st_r == StClear) begin
      sum_mem[clr_r] <= 48'd0;
      sq_mem[clr_r] <= 64'd0;
      cnt_mem[clr_r] <= 20'd0;
    end else if (we) begin
      sum_mem[job_r.row] <= new_sum;
      sq_mem[job_r.row] <= new_sq;
      cnt_mem[job_r.row] <= (c_r == CountMax) ? c_r : c_r + 20'd1;
    end
    if (st_r == StRead) begin
      s1_r <= sum_mem[job_r.row];
      s2_r <= sq_mem[job_r.row];
      c_r <= cnt_mem[job_r.row];
    end
    if (st_r == StMul) begin
      mag_r <= mag_nxt;
    end
    job_r <= job_nxt;
    acc_r <= acc_nxt;
    sr_r <= sr_nxt;
    bit_r <= bit_nxt;
    rem_r <= rem_nxt;
    sq_cnt_r <= sq_cnt_nxt;
    ov_r <= ov_nxt;
    std_r <= std_nxt;
    osum_r <= osum_nxt;
    osq_r <= osq_nxt;
    ocnt_r <= ocnt_nxt;
    orng_r <= orng_nxt;
    if (!rst_n) begin
      st_r <= StClear;
      mstep_r <= 2'd0;
      ovalid_r <= 1'b0;
      clr_r <= '0;
    end else begin
      st_r <= st_nxt;
      mstep_r <= mstep_nxt;
      ovalid_r <= ovalid_nxt;
      if (flush) begin
        clr_r <= '0;
      end else if (st_r == StClear) begin
        clr_r <= clr_r + RowW'(1);
      end
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPL(a_take_only_idle, clk, rst_n, q_ready, st_r == StIdle,
               "job taken outside the idle state")
  `ASSERT_IMPL(a_no_write_clear, clk, rst_n, st_r == StClear, !we,
               "store written during clearing")
  `ASSERT_NEXT(a_out_holds, clk, rst_n, ovalid_r && !out_ready, ovalid_r,
               "result dropped before taken")
endmodule

// File: hdl/sparse_row_stddev_accumulator_unit.sv
`timescale 1ns / 1ps
// An accumulate request occupies the back end through its idle, read and accumulate
// states, and no new request is taken until it is done; the two-entry queue takes one
// request per cycle until full and none during a configuration write. A read of an
// in-range row goes through two 96-step bit-serial divisions and a 32-step square root.
// Synchronous active-low reset; after reset and after every configuration write a
// clearing pass over all 1024 rows runs before queued requests are carried out.
module sparse_row_stddev_accumulator_unit
  import srsa_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // row_index, column_index, weight, zero pad
  input  logic [55:0]  in_tdata,
  // command
  input  logic         in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // std_dev, row_sum, row_sum_squares, entry_count, row_in_range, zero pad
  output logic [159:0] out_tdata,
  input  logic         cfg_we,
  input  logic [0:0]   cfg_index,
  input  logic [20:0]  cfg_data
);
  logic [10:0] row_count_r;
  logic [20:0] column_count_r;
  logic        flush;
  logic        q_valid, q_ready;
  job_t        q_job;
  logic        front_ready;
  logic [23:0] std_dev;
  logic [47:0] row_sum;
  logic [63:0] row_sum_squares;
  logic [19:0] entry_count;
  logic        row_in_range;

  assign flush = cfg_we;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= 11'd1024;
      column_count_r <= 21'd1048576;
    end else if (cfg_we) begin
      if (cfg_index == RegRowCount) begin
        row_count_r <= cfg_data[10:0];
      end else begin
        column_count_r <= cfg_data;
      end
    end
  end

  srsa_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid),
    .in_ready(front_ready), .cmd(in_tuser), .row(in_tdata[9:0]),
    .col(in_tdata[29:10]), .weight(in_tdata[53:30]), .row_count(row_count_r),
    .column_count(column_count_r), .flush(flush), .q_valid(q_valid),
    .q_ready(q_ready), .q_job(q_job)
  );

  assign in_tready = front_ready && !flush;

  srsa_back u_back (
    .clk(clk), .rst_n(rst_n), .flush(flush), .column_count(column_count_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_job(q_job),
    .out_valid(out_tvalid), .out_ready(out_tready), .std_dev(std_dev),
    .row_sum(row_sum), .row_sum_squares(row_sum_squares),
    .entry_count(entry_count), .row_in_range(row_in_range)
  );

  assign out_tdata = {3'd0, row_in_range, entry_count, row_sum_squares, row_sum, std_dev};
endmodule

// File: tb/sv/sparse_row_stddev_accumulator_unit_tb.sv
`timescale 1ns / 1ps
module sparse_row_stddev_accumulator_unit_tb;
  import srsa_pkg::*;

  typedef struct packed {
    logic        in_range;
    logic [19:0] count;
    logic [63:0] sum_sq;
    logic [47:0] sum;
    logic [23:0] std_dev;
  } row_stats_t;

  class row_stats_board;
    logic signed [47:0] sum_mem [MaxRows];
    logic [63:0]        sq_mem [MaxRows];
    logic [19:0]        count_mem [MaxRows];
    logic [10:0]        row_count;
    logic [20:0]        col_count;
    row_stats_t         stats_q [$];
    int                 errors;

    function void clear_rows();
      for (int i = 0; i < MaxRows; i++) begin
        sum_mem[i] = '0;
        sq_mem[i] = '0;
        count_mem[i] = '0;
      end
    endfunction

    function void reset_state();
      row_count = 11'd1024;
      col_count = 21'd1048576;
      errors = 0;
      clear_rows();
    endfunction

    function void set_register(logic [0:0] idx, logic [20:0] value);
      if (idx == RegRowCount) row_count = value[10:0];
      else col_count = value;
      clear_rows();
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] bitv;
      res = '0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function logic [23:0] std_dev_of(logic signed [47:0] s1, logic [63:0] s2,
                                     logic [20:0] n);
      logic [127:0] mag;
      logic [127:0] quot;
      logic [63:0]  q;
      logic [63:0]  m;
      logic [63:0]  r;
      mag = s1[47] ? {80'd0, -s1} : {80'd0, s1};
      q = '0;
      if (n != 0) begin
        quot = (mag * mag) / {107'd0, n};
        if (quot[127:64] != 0) return '0;
        q = quot[63:0];
      end
      if (q > s2) return '0;
      m = (n > 1) ? {43'd0, n} - 64'd1 : 64'd1;
      r = int_sqrt((s2 - q) / m);
      return (r > 64'hFFFFFF) ? 24'hFFFFFF : r[23:0];
    endfunction

    function void note_request(logic cmd, logic [55:0] data);
      logic [9:0]          row;
      logic [19:0]         col;
      logic signed [23:0]  w;
      logic signed [48:0]  s;
      logic [64:0]         sq;
      logic [63:0]         w2;
      logic                in_use;
      row_stats_t          res;
      row = data[9:0];
      col = data[29:10];
      w = data[53:30];
      in_use = {1'b0, row} < row_count;
      if (cmd == CmdAcc) begin
        if (!in_use || {1'b0, col} >= col_count) return;
        s = sum_mem[row] + w;
        if (s > 49'sh7FFFFFFFFFFF) s = 49'sh7FFFFFFFFFFF;
        if (s < -49'sh800000000000) s = -49'sh800000000000;
        sum_mem[row] = s[47:0];
        w2 = 64'(w) * 64'(w);
        sq = {1'b0, sq_mem[row]} + {1'b0, w2};
        sq_mem[row] = sq[64] ? '1 : sq[63:0];
        if (count_mem[row] != CountMax) count_mem[row] = count_mem[row] + 20'd1;
        return;
      end
      res = '0;
      if (in_use) begin
        res.std_dev = std_dev_of(sum_mem[row], sq_mem[row], col_count);
        res.sum = sum_mem[row];
        res.sum_sq = sq_mem[row];
        res.count = count_mem[row];
        res.in_range = 1'b1;
      end
      stats_q.insert(stats_q.size(), res);
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h", what, got, want);
      errors++;
    endtask

    task check_result(logic [159:0] data);
      row_stats_t got;
      row_stats_t want;
      got = data[156:0];
      if (stats_q.size() == 0) begin
        report("unexpected result", {7'd0, got.in_range, got.count, got.std_dev, 12'd0},
               64'd0);
        return;
      end
      want = stats_q.pop_front();
      if (got.std_dev !== want.std_dev)
        report("std_dev", 64'(got.std_dev), 64'(want.std_dev));
      if (got.sum !== want.sum) report("row_sum", 64'(got.sum), 64'(want.sum));
      if (got.sum_sq !== want.sum_sq) report("row_sum_squares", got.sum_sq, want.sum_sq);
      if (got.count !== want.count) report("entry_count", 64'(got.count), 64'(want.count));
      if (got.in_range !== want.in_range)
        report("row_in_range", 64'(got.in_range), 64'(want.in_range));
      if (data[159:157] !== 3'd0) report("padding", 64'(data[159:157]), 64'd0);
    endtask
  endclass

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [55:0]  in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [159:0] out_tdata;
  logic         cfg_we;
  logic [0:0]   cfg_index;
  logic [20:0]  cfg_data;

  row_stats_board board;
  bit  gaps_on;
  bit  long_hold;
  int  quiet_cycles = 0;

  sparse_row_stddev_accumulator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.note_request(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Result side: a random hold-off before each result while gaps are on, or one long one on request.
  initial begin
    int gap;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = gaps_on ? $urandom_range(0, 13) : 0;
      if (long_hold) begin
        gap = 600;
        long_hold = 1'b0;
      end
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_request(logic cmd, logic [9:0] row, logic [19:0] col, logic [23:0] w);
    int gap;
    gap = gaps_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= cmd;
    in_tdata <= {2'b00, w, col, row};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Waits out the clearing pass and any queued accumulate requests as well.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.stats_q.size() != 0) @(posedge clk);
    repeat (1040) @(posedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [20:0] value);
    drain_results();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_register(idx, value);
  endtask

  task automatic random_phase(int count, int rows, int cols);
    logic [9:0]  row;
    logic [19:0] col;
    logic [23:0] w;
    logic        cmd;
    for (int i = 0; i < count; i++) begin
      cmd = ($urandom_range(0, 4) == 0) ? CmdRead : CmdAcc;
      row = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, rows));
      col = ($urandom_range(0, 7) == 0 || cols == 0) ? 20'($urandom)
                                                     : 20'($urandom_range(0, cols - 1));
      case ($urandom_range(0, 5))
        0: w = 24'h7FFFFF;
        1: w = 24'h800000;
        2: w = 24'($urandom_range(0, 2047)) - 24'd1024;
        default: w = 24'($urandom);
      endcase
      if (i == count / 2 && !gaps_on) gaps_on = 1'b1;
      send_request(cmd, row, col, w);
    end
  endtask

  initial begin
    board = new();
    board.reset_state();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_we = 1'b0;
    cfg_index = RegRowCount;
    cfg_data = '0;
    gaps_on = 1'b1;
    long_hold = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    send_request(CmdAcc, 10'd0, 20'hFFFFF, 24'h7FFFFF);
    send_request(CmdAcc, 10'd0, 20'd0, 24'h800000);
    send_request(CmdAcc, 10'd1023, 20'd3, 24'h000000);
    send_request(CmdAcc, 10'd1023, 20'd7, 24'hFFFFFF);
    send_request(CmdRead, 10'd0, 20'd0, 24'h0);
    send_request(CmdRead, 10'd1023, 20'hFFFFF, 24'hFFFFFF);
    send_request(CmdRead, 10'd5, 20'd0, 24'h0);

    write_register(RegColCount, 21'd2);
    send_request(CmdAcc, 10'd2, 20'd0, 24'h7FFFFF);
    send_request(CmdAcc, 10'd2, 20'd1, 24'h800000);
    send_request(CmdAcc, 10'd2, 20'd0, 24'h7FFFFF);
    send_request(CmdAcc, 10'd2, 20'd1, 24'h800000);
    send_request(CmdAcc, 10'd2, 20'd2, 24'h000100);
    send_request(CmdRead, 10'd2, 20'd0, 24'h0);

    write_register(RegColCount, 21'd1);
    write_register(RegRowCount, 21'd3);
    send_request(CmdAcc, 10'd1, 20'd0, 24'h000A00);
    send_request(CmdAcc, 10'd1, 20'd0, 24'h000A00);
    send_request(CmdAcc, 10'd3, 20'd0, 24'h000100);
    send_request(CmdRead, 10'd1, 20'd0, 24'h0);
    send_request(CmdRead, 10'd3, 20'd0, 24'h0);

    write_register(RegColCount, 21'd0);
    send_request(CmdAcc, 10'd0, 20'd0, 24'h000100);
    send_request(CmdRead, 10'd0, 20'd0, 24'h0);
    write_register(RegRowCount, 21'd0);
    send_request(CmdRead, 10'd0, 20'd0, 24'h0);

    write_register(RegRowCount, 21'd1024);
    write_register(RegColCount, 21'd1048576);
    gaps_on = 1'b0;
    random_phase(100, 12, 1 << 20);

    write_register(RegRowCount, 21'd16);
    write_register(RegColCount, 21'd64);
    long_hold = 1'b1;
    random_phase(100, 18, 64);

    write_register(RegRowCount, 21'h1FFFFF);
    write_register(RegColCount, 21'h1FFFFF);
    random_phase(50, 1023, 1 << 20);
    drain_results();
    random_phase(50, 8, 1 << 20);

    write_register(RegRowCount, 21'd1);
    write_register(RegColCount, 21'd1);
    random_phase(80, 2, 1);

    write_register(RegRowCount, 21'd7);
    write_register(RegColCount, 21'd3);
    gaps_on = 1'b0;
    random_phase(120, 8, 3);

    drain_results();
    repeat (300) @(posedge clk);
    if (board.errors == 0 && board.stats_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
